[hdl/mmmf_pkg.sv]
// Shared constants and types of the multichannel median/mean filter.
package mmmf_pkg;

   localparam int CHANNELS       = 4;
   localparam int WINDOW_SAMPLES = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int RUN_LEN        = 5;
   localparam int RUN_MID        = 2;

   localparam int CHAN_BITS   = 2;
   localparam int POS_BITS    = $clog2(WINDOW_SAMPLES);
   localparam int CNT_BITS    = $clog2(WINDOW_SAMPLES + 1);
   localparam int DEPTH       = CHANNELS * WINDOW_SAMPLES;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
   localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [RUN_LEN-1:0] run_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_DRAIN = 4'b0100,
      S_HOLD  = 4'b1000
   } state_type;

endpackage

[hdl/mmmf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mmmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/multichannel_median_mean_filter.sv]
// Top level of the multichannel sliding median-of-five and mean filter.
//
// Input channel (req_): one transfer carries a sample and the channel whose
// window receives it. The sample is written into that channel's window, the
// window is read back oldest first from the window RAM, every run of five
// neighbouring samples gives a median, and the medians are summed and divided
// by the window length with an arithmetic shift (rounding toward minus
// infinity).
// Result channel (rsp_): one transfer per input, the filtered value and the
// channel it belongs to.
// The window is read from the window RAM one sample per cycle; a channel
// outside the configured range skips the window read and returns 0. One
// item is worked on at a time, so a new transfer is taken only after the
// result of the last one has been moved to the output register.
// Reset clears every window to zero through per-entry valid bits, so no
// clearing pass is needed, and sets every write position to zero.
// A stalled receiver leaves the result in the output register; the next item
// is still taken and worked on, and waits for the output register to free.
module multichannel_median_mean_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mmmf_pkg::DATA_BITS-1:0] req_tdata,  // [15:0] sample
   input  logic [mmmf_pkg::CHAN_BITS-1:0] req_tuser,  // [1:0] channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mmmf_pkg::DATA_BITS-1:0] rsp_tdata,  // [15:0] filtered
   output logic [mmmf_pkg::CHAN_BITS-1:0] rsp_tuser   // [1:0] out_channel
);
   import mmmf_pkg::*;

   // Median of five: the element whose rank is the middle one, ties broken by
   // position so that exactly one element qualifies.
   function automatic sample_type median5(input run_type w);
      sample_type  med;
      logic [2:0]  rank;
      med = w[0];
      for (int j = 0; j < RUN_LEN; j++) begin
         rank = '0;
         for (int k = 0; k < RUN_LEN; k++) begin
            if (k != j) begin
               if ((w[k] < w[j]) || ((w[k] == w[j]) && (k < j))) begin
                  rank = rank + 3'd1;
               end
            end
         end
         if (rank == 3'(RUN_MID)) begin
            med = w[j];
         end
      end
      return med;
   endfunction

   // Control registers.
   state_type               state_ff, state_in;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [POS_BITS-1:0]     wp_ff [CHANNELS];
   logic [POS_BITS-1:0]     wp_in [CHANNELS];
   logic [POS_BITS-1:0]     icnt_ff, icnt_in;
   logic [CNT_BITS-1:0]     fcnt_ff, fcnt_in;
   logic                    iss_v_ff, iss_v_in;
   logic                    mq_v_ff, mq_v_in;
   logic                    mq_last_ff, mq_last_in;
   logic                    md_v_ff, md_v_in;
   logic                    md_last_ff, md_last_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;

   // Payload registers.
   logic [CHAN_BITS-1:0]    ch_ff, ch_in;
   sample_type              sample_ff, sample_in;
   logic [POS_BITS-1:0]     rd_pos_ff, rd_pos_in;
   logic                    iss_ram_ff, iss_ram_in;
   logic                    iss_last_ff, iss_last_in;
   logic                    rdv_ff, rdv_in;
   run_type                 sh_ff, sh_in;
   sample_type              med_ff, med_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   sample_type              res_ff, res_in;
   logic [DATA_BITS-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic [CHAN_BITS-1:0]    rsp_tuser_ff, rsp_tuser_in;

   // Combinational signals.
   logic                    accept;
   logic                    ch_ok;
   logic [POS_BITS-1:0]     wr_pos;
   logic [POS_BITS-1:0]     wr_pos_next;
   logic                    ram_wr_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr;
   logic                    ram_rd_en;
   logic [ADDR_BITS-1:0]    ram_rd_addr;
   logic [SAMPLE_BITS-1:0]  ram_rd_data;
   sample_type              feed_data;
   logic signed [SUM_BITS-1:0] sum_next;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ch_ok      = (32'(req_tuser) < CHANNELS);
   assign wr_pos     = wp_ff[CH_IDX_BITS'(req_tuser)];
   assign wr_pos_next = (wr_pos == POS_BITS'(WINDOW_SAMPLES - 1)) ? '0 : wr_pos + 1'b1;

   assign ram_wr_en   = accept && ch_ok;
   assign ram_wr_addr = ADDR_BITS'(req_tuser) * ADDR_BITS'(WINDOW_SAMPLES)
                        + ADDR_BITS'(wr_pos);
   // The last slot of the window is the new sample itself, so it is not read back.
   assign ram_rd_en   = (state_ff == S_ISSUE) && (icnt_ff != POS_BITS'(WINDOW_SAMPLES - 1));
   assign ram_rd_addr = ADDR_BITS'(ch_ff) * ADDR_BITS'(WINDOW_SAMPLES)
                        + ADDR_BITS'(rd_pos_ff);

   mmmf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry never written since reset reads as zero.
   assign feed_data = iss_ram_ff ? (rdv_ff ? sample_type'(ram_rd_data) : '0) : sample_ff;
   assign sum_next  = sum_ff + SUM_BITS'(med_ff);

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      wp_in         = wp_ff;
      icnt_in       = icnt_ff;
      fcnt_in       = fcnt_ff;
      iss_v_in      = 1'b0;
      mq_v_in       = 1'b0;
      mq_last_in    = 1'b0;
      md_v_in       = 1'b0;
      md_last_in    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff;
      ch_in         = ch_ff;
      sample_in     = sample_ff;
      rd_pos_in     = rd_pos_ff;
      iss_ram_in    = iss_ram_ff;
      iss_last_in   = iss_last_ff;
      rdv_in        = rdv_ff;
      sh_in         = sh_ff;
      med_in        = med_ff;
      sum_in        = sum_ff;
      res_in        = res_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      // Window pipeline: feed one sample, then median, then accumulate.
      if (iss_v_ff) begin
         sh_in      = run_type'({sh_ff[RUN_LEN-2:0], feed_data});
         fcnt_in    = fcnt_ff + 1'b1;
         mq_v_in    = (fcnt_ff >= CNT_BITS'(RUN_LEN - 1));
         mq_last_in = iss_last_ff;
      end
      if (mq_v_ff) begin
         med_in     = median5(sh_ff);
         md_v_in    = 1'b1;
         md_last_in = mq_last_ff;
      end
      if (md_v_ff) begin
         sum_in = sum_next;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_in     = req_tuser;
               sample_in = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
               icnt_in   = '0;
               fcnt_in   = '0;
               sum_in    = '0;
               if (ch_ok) begin
                  valid_in[ram_wr_addr]         = 1'b1;
                  wp_in[CH_IDX_BITS'(req_tuser)] = wr_pos_next;
                  rd_pos_in = wr_pos_next;
                  state_in  = S_ISSUE;
               end else begin
                  res_in   = '0;
                  state_in = S_HOLD;
               end
            end
         end
         S_ISSUE: begin
            iss_v_in    = 1'b1;
            iss_ram_in  = ram_rd_en;
            iss_last_in = !ram_rd_en;
            rdv_in      = valid_ff[ram_rd_addr];
            rd_pos_in   = (rd_pos_ff == POS_BITS'(WINDOW_SAMPLES - 1)) ? '0
                          : rd_pos_ff + 1'b1;
            icnt_in     = icnt_ff + 1'b1;
            if (!ram_rd_en) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (md_last_ff) begin
               // Floor division by the window length.
               res_in   = sample_type'(sum_next >>> POS_BITS);
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = DATA_BITS'(unsigned'(res_ff));
               rsp_tuser_in  = ch_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         wp_ff         <= '{default: '0};
         icnt_ff       <= '0;
         fcnt_ff       <= '0;
         iss_v_ff      <= 1'b0;
         mq_v_ff       <= 1'b0;
         mq_last_ff    <= 1'b0;
         md_v_ff       <= 1'b0;
         md_last_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         wp_ff         <= wp_in;
         icnt_ff       <= icnt_in;
         fcnt_ff       <= fcnt_in;
         iss_v_ff      <= iss_v_in;
         mq_v_ff       <= mq_v_in;
         mq_last_ff    <= mq_last_in;
         md_v_ff       <= md_v_in;
         md_last_ff    <= md_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      sample_ff    <= sample_in;
      rd_pos_ff    <= rd_pos_in;
      iss_ram_ff   <= iss_ram_in;
      iss_last_ff  <= iss_last_in;
      rdv_ff       <= rdv_in;
      sh_ff        <= sh_in;
      med_ff       <= med_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef NO_ASSERTIONS
   // The final median reaches the accumulator only while the block waits for it.
   assert property (@(posedge clock) disable iff (reset)
      md_last_ff |-> (state_ff == S_DRAIN))
      else $error("last median arrived outside the drain phase");

   // A window read in flight belongs to the item being worked on.
   assert property (@(posedge clock) disable iff (reset)
      iss_v_ff |-> ((state_ff == S_ISSUE) || (state_ff == S_DRAIN)))
      else $error("window sample fed while no item is in progress");

   // An accepted transfer starts the window read or goes straight to the result.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == S_ISSUE) || (state_ff == S_HOLD)))
      else $error("accepted transfer did not start work");

   // No more samples are fed than the window holds.
   assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CNT_BITS'(WINDOW_SAMPLES))
      else $error("feed count ran past the window length");
`endif

endmodule
